// ===== hdl/iaop_pkg.sv =====
// iaop_pkg: shared widths, defaults and the group table entry type
// for the interval alias offset planner. No dependencies.
`timescale 1ns / 1ps

package iaop_pkg;

    localparam int IAOP_MAX_GROUPS = 16;

    localparam int TAG_W   = 16;
    localparam int BATCH_W = 16;
    localparam int OFF_W   = 48;
    localparam int ALIGN_W = 5;
    localparam int SLOT_W  = 4;

    localparam int IN_W  = 104;
    localparam int OUT_W = 120;

    typedef struct packed {
        logic [BATCH_W-1:0] end_batch;
        logic [OFF_W-1:0]   next_offset;
    } grp_entry_t;

endpackage

// ===== hdl/interval_alias_offset_planner.sv =====
// interval_alias_offset_planner: first-fit placement of resources into lifetime
// groups; the group table is a synchronous memory scanned one entry a cycle.
// Depends on iaop_pkg.
//
// channel  dir  tdata fields (low bit first)
// s_*      in   first_of_plan, resource_tag, start_batch, end_batch, byte_size, align_log2
// m_*      out  result_tag, placed_offset, group_slot, opened_group, peak_bytes, overflow
//
// One item at a time. An accepted item goes through the align and commit steps
// directly when no group is live or first_of_plan is set, else it first scans
// the table in order, up to and including the first reusable entry, or all
// groups when none is reusable. The table is read one entry a cycle into a read
// data register; the planner returns to idle as the result is registered.
// Reset clears the group count and peak; table entries are written before read.
// A result waiting in the output register stalls only the final commit step.
`timescale 1ns / 1ps

module interval_alias_offset_planner
    import iaop_pkg::*;
#(
    parameter int MAX_GROUPS = IAOP_MAX_GROUPS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // first_of_plan, resource_tag, start_batch, end_batch, byte_size, align_log2
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result_tag, placed_offset, group_slot, opened_group, peak_bytes, overflow
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(MAX_GROUPS + 1);
    localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_ALIGN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    // input fields
    logic               in_first;
    logic [TAG_W-1:0]   in_tag;
    logic [BATCH_W-1:0] in_start;
    logic [BATCH_W-1:0] in_end;
    logic [OFF_W-1:0]   in_size;
    logic [ALIGN_W-1:0] in_align;

    assign in_first = s_tdata[0];
    assign in_tag   = s_tdata[16:1];
    assign in_start = s_tdata[32:17];
    assign in_end   = s_tdata[48:33];
    assign in_size  = s_tdata[96:49];
    assign in_align = s_tdata[101:97];

    logic [1:0]         state_reg, state_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [BATCH_W-1:0] start_reg, start_next;
    logic [BATCH_W-1:0] end_reg, end_next;
    logic [OFF_W-1:0]   size_reg, size_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [OFF_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [OFF_W-1:0]   base_reg, base_next;
    logic               ovf_reg, ovf_next;
    logic               opened_reg, opened_next;
    logic [OFF_W:0]     placed_reg, placed_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;

    // group table
    grp_entry_t         grp_mem [MAX_GROUPS];
    grp_entry_t         rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    grp_entry_t         wr_data;

    logic               out_free;
    logic [OFF_W:0]     amask;
    logic [OFF_W+1:0]   top;
    logic               fin_ovf;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign amask    = ((OFF_W+1)'(1) << align_reg) - (OFF_W+1)'(1);
    assign top      = {1'b0, placed_reg} + {2'b00, size_reg};
    assign fin_ovf  = ovf_reg || (top[OFF_W+1:OFF_W] != 2'b00);
    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};

    always_comb
    begin
        state_next      = state_reg;
        tag_next        = tag_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        base_next       = base_reg;
        ovf_next        = ovf_reg;
        opened_next     = opened_reg;
        placed_next     = placed_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data.end_batch   = end_reg;
        wr_data.next_offset = top[OFF_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    tag_next    = in_tag;
                    start_next  = in_start;
                    end_next    = in_end;
                    size_next   = in_size;
                    align_next  = in_align;
                    issue_next  = '0;
                    found_next  = 1'b0;
                    base_next   = '0;
                    ovf_next    = 1'b0;
                    opened_next = 1'b0;
                    if (in_first)
                    begin
                        count_next = '0;
                        peak_next  = '0;
                    end
                    if (in_first || count_reg == '0)
                        state_next = S_ALIGN;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en = (issue_reg < count_reg);
                if (rd_en)
                begin
                    issue_next      = issue_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (pend_valid_reg)
                begin
                    if (rd_data_reg.end_batch < start_reg)
                    begin
                        found_next      = 1'b1;
                        slot_next       = pend_idx_reg;
                        base_next       = rd_data_reg.next_offset;
                        pend_valid_next = 1'b0;
                        state_next      = S_ALIGN;
                    end
                    else
                    begin
                        if (rd_data_reg.next_offset > base_reg)
                            base_next = rd_data_reg.next_offset;
                        if ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == count_reg)
                            state_next = S_ALIGN;
                    end
                end
            end
            S_ALIGN:
            begin
                if (!found_reg)
                begin
                    if (count_reg == CNT_W'(MAX_GROUPS))
                    begin
                        ovf_next  = 1'b1;
                        slot_next = '0;
                    end
                    else
                    begin
                        opened_next = 1'b1;
                        slot_next   = count_reg[IDX_W-1:0];
                    end
                end
                placed_next = ({1'b0, base_reg} + amask) & ~amask;
                state_next  = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    if (!fin_ovf)
                    begin
                        wr_en = 1'b1;
                        if (opened_reg)
                            count_next = count_reg + CNT_W'(1);
                        if (top[OFF_W-1:0] > peak_reg)
                            peak_next = top[OFF_W-1:0];
                    end
                    m_data_next = '0;
                    m_data_next[15:0]   = tag_reg;
                    m_data_next[63:16]  = fin_ovf ? '0 : placed_reg[OFF_W-1:0];
                    m_data_next[67:64]  = slot_ext[SLOT_W-1:0];
                    m_data_next[68]     = opened_reg && !fin_ovf;
                    m_data_next[116:69] = (!fin_ovf && top[OFF_W-1:0] > peak_reg) ?
                                          top[OFF_W-1:0] : peak_reg;
                    m_data_next[117]    = fin_ovf;
                    m_valid_next        = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grp_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= grp_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            peak_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            peak_reg       <= peak_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        size_reg     <= size_next;
        align_reg    <= align_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        base_reg     <= base_next;
        ovf_reg      <= ovf_next;
        opened_reg   <= opened_next;
        placed_reg   <= placed_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== test/interval_alias_offset_planner_tb.sv =====
// interval_alias_offset_planner_tb: self-checking bench for the first-fit
// lifetime-group offset planner; a scoreboard class predicts each placement.
// Depends on iaop_pkg and interval_alias_offset_planner.
`timescale 1ns / 1ps

module interval_alias_offset_planner_tb;
    import iaop_pkg::*;

    localparam int  ITEMS_PER_PHASE = 200;
    localparam int  CYCLE_LIMIT     = 400000;
    localparam int  SETTLE_CYCLES   = 30;
    localparam logic [63:0] OFF_MAX = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        bit                 first;
        bit [TAG_W-1:0]     tag;
        bit [BATCH_W-1:0]   start;
        bit [BATCH_W-1:0]   last_batch;
        bit [OFF_W-1:0]     size;
        bit [ALIGN_W-1:0]   lg;
    } resource_t;

    typedef struct {
        logic [TAG_W-1:0]   tag;
        logic [OFF_W-1:0]   offset;
        logic [SLOT_W-1:0]  slot;
        logic               opened;
        logic [OFF_W-1:0]   peak;
        logic               ovf;
    } placement_t;

    class planner_scoreboard;
        logic [OFF_W-1:0]   grp_offset [IAOP_MAX_GROUPS];
        logic [BATCH_W-1:0] grp_end    [IAOP_MAX_GROUPS];
        int                 grp_count;
        logic [OFF_W-1:0]   peak_size;
        placement_t         expected_placements[$];
        int                 errors;
        int                 n_checked;
        int                 n_opened;
        int                 n_overflow;

        function new();
            grp_count  = 0;
            peak_size  = '0;
            errors     = 0;
            n_checked  = 0;
            n_opened   = 0;
            n_overflow = 0;
        endfunction

        function logic [63:0] round_up(logic [63:0] off, bit [ALIGN_W-1:0] lg);
            logic [63:0] a;
            a = 64'd1 << lg;
            return (off + a - 64'd1) & ~(a - 64'd1);
        endfunction

        function void note_resource(resource_t r);
            placement_t  p;
            bit          found;
            int          slot;
            int          i;
            logic [63:0] placed;
            logic [63:0] mx;
            logic [63:0] top;
            if (r.first)
            begin
                grp_count = 0;
                peak_size = '0;
            end
            found  = 0;
            slot   = 0;
            placed = '0;
            p.opened = 1'b0;
            p.ovf    = 1'b0;
            for (i = 0; i < grp_count; i++)
            begin
                if (!found && grp_end[i] < r.start)
                begin
                    found = 1;
                    slot  = i;
                end
            end
            if (found)
                placed = round_up({16'd0, grp_offset[slot]}, r.lg);
            else if (grp_count >= IAOP_MAX_GROUPS)
                p.ovf = 1'b1;
            else
            begin
                mx = '0;
                for (i = 0; i < grp_count; i++)
                begin
                    if (grp_end[i] >= r.start && {16'd0, grp_offset[i]} > mx)
                        mx = {16'd0, grp_offset[i]};
                end
                slot     = grp_count;
                placed   = round_up(mx, r.lg);
                p.opened = 1'b1;
            end
            if (!p.ovf)
            begin
                top = placed + {16'd0, r.size};
                if (top > OFF_MAX)
                begin
                    p.ovf    = 1'b1;
                    p.opened = 1'b0;
                    placed   = '0;
                end
                else
                begin
                    grp_offset[slot] = top[OFF_W-1:0];
                    grp_end[slot]    = r.last_batch;
                    if (p.opened)
                        grp_count++;
                    if (top[OFF_W-1:0] > peak_size)
                        peak_size = top[OFF_W-1:0];
                end
            end
            p.tag    = r.tag;
            p.offset = placed[OFF_W-1:0];
            p.slot   = slot[SLOT_W-1:0];
            p.peak   = peak_size;
            expected_placements.insert(expected_placements.size(), p);
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_placement(logic [OUT_W-1:0] d);
            placement_t want;
            placement_t got;
            got.tag    = d[15:0];
            got.offset = d[63:16];
            got.slot   = d[67:64];
            got.opened = d[68];
            got.peak   = d[116:69];
            got.ovf    = d[117];
            if (expected_placements.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tag %0h", $time, got.tag);
                errors++;
                return;
            end
            want = expected_placements.pop_front();
            n_checked++;
            if (want.opened)
                n_opened++;
            if (want.ovf)
                n_overflow++;
            report_field("result_tag", 64'(want.tag), 64'(got.tag));
            report_field("placed_offset", 64'(want.offset), 64'(got.offset));
            report_field("group_slot", 64'(want.slot), 64'(got.slot));
            report_field("opened_group", 64'(want.opened), 64'(got.opened));
            report_field("peak_bytes", 64'(want.peak), 64'(got.peak));
            report_field("overflow", 64'(want.ovf), 64'(got.ovf));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    planner_scoreboard sb = new();
    int                tx_idle_pct;
    int                rx_stall_pct;
    int                n_sent;
    int                cycles = 0;

    interval_alias_offset_planner dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_placement(m_tdata);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     sb.expected_placements.size());
            $display("interval_alias_offset_planner_tb: FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_resource(resource_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, r.lg, r.size, r.last_batch, r.start, r.tag, r.first};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_resource(r);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_placements.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_fields(bit first, bit [15:0] tag, bit [15:0] start,
                               bit [15:0] stop, bit [47:0] size, bit [4:0] lg);
        resource_t r;
        r.first      = first;
        r.tag        = tag;
        r.start      = start;
        r.last_batch = stop;
        r.size       = size;
        r.lg         = lg;
        send_resource(r);
    endtask

    task automatic run_plan(int len, int target);
        int        i;
        int        base;
        int        t;
        int        roll;
        resource_t r;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            base = $urandom_range(0, 300);
        else if (roll < 8)
            base = $urandom_range(0, 65535);
        else
            base = $urandom_range(65000, 65535);
        for (i = 0; i < len && n_sent < target; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                // noise: unordered, unrelated item
                r.first      = 1'($urandom_range(0, 1));
                r.tag        = 16'($urandom);
                r.start      = 16'($urandom);
                r.last_batch = 16'($urandom);
                r.size       = 48'({$urandom, $urandom});
                r.lg         = 5'($urandom);
            end
            else
            begin
                base = base + $urandom_range(0, 3);
                if (base > 65535)
                    base = 65535;
                t = base + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                        : $urandom_range(0, 6));
                if (t > 65535)
                    t = 65535;
                r.first      = (i == 0);
                r.tag        = 16'($urandom);
                r.start      = 16'(base);
                r.last_batch = 16'(t);
                if ($urandom_range(0, 19) == 0)
                    r.last_batch = 16'($urandom);
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    r.size = '0;
                else if (roll == 1)
                    r.size = 48'({$urandom, $urandom});
                else if (roll < 5)
                    r.size = 48'($urandom);
                else
                    r.size = 48'($urandom_range(1, 4096));
                r.lg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 6));
            end
            send_resource(r);
            if ($urandom_range(0, 99) == 0)
                drain();
        end
    endtask

    initial
    begin
        int phase;
        int i;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        n_sent       = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero size, reuse, alignment extremes, range overflow on reuse
        send_fields(1'b1, 16'h0000, 16'd0, 16'd0, 48'd0, 5'd0);
        send_fields(1'b0, 16'hFFFF, 16'd0, 16'd10, 48'd100, 5'd3);
        send_fields(1'b0, 16'h0002, 16'd1, 16'd3, 48'd64, 5'd6);
        send_fields(1'b0, 16'h0003, 16'd11, 16'd20, 48'hFFFF_FFFF_FFFF, 5'd0);
        send_fields(1'b0, 16'h0004, 16'd11, 16'd20, 48'd1000, 5'd31);
        send_fields(1'b0, 16'h0005, 16'hFFFF, 16'd0, 48'd5, 5'd31);
        // table full
        for (i = 0; i < IAOP_MAX_GROUPS + 1; i++)
            send_fields(i == 0, 16'h0100 + 16'(i), 16'd100, 16'hFFFF, 48'd8, 5'd2);
        // range overflow when opening a group
        send_fields(1'b1, 16'h0200, 16'd0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 5'd0);
        send_fields(1'b0, 16'h0201, 16'd0, 16'hFFFF, 48'd1, 5'd0);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            while (n_sent < ITEMS_PER_PHASE * (phase + 1))
                run_plan($urandom_range(1, 40), ITEMS_PER_PHASE * (phase + 1));
            drain();
        end

        $display("Sent %0d resources over four handshake phases; %0d placements checked,",
                 n_sent, sb.n_checked);
        $display("%0d opened a group, %0d flagged overflow.", sb.n_opened, sb.n_overflow);
        if (sb.errors == 0 && sb.expected_placements.size() == 0)
            $display("interval_alias_offset_planner_tb: PASS");
        else
            $display("interval_alias_offset_planner_tb: FAIL");
        $finish;
    end

endmodule
